>>> rtl/core/moi_pkg.sv
// Package for the mecanum odometry integrator: widths, CORDIC table, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package moi_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;
    localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;
    localparam logic [0:0] REG_LINEAR_GAIN = 1'b0;
    localparam logic [0:0] REG_ANGLE_GAIN = 1'b1;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001; default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HMUL  = 7'b0000010,
        ST_CORD  = 7'b0000100,
        ST_VMUL  = 7'b0001000,
        ST_GMUL  = 7'b0010000,
        ST_ACC   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

>>> rtl/core/mecanum_odometry_integrator_core.sv
// Top level of the mecanum odometry integrator: bit-serial multipliers, iterative CORDIC.
// Depends on moi_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir  | Contents
// s_      | in   | tdata: wheel_position_a..d (4x32), tuser: clear_pose
// m_      | out  | tdata: pose_x, pose_y (48 each), heading (32)
// cfg_    | in   | index 0 linear_gain, index 1 angle_gain
//
// A clear or unprimed request shows its result on m_ the cycle after it is accepted.
// An integrating request runs the heading multiply, the CORDIC (angle loaded at the end
// of the multiply), four vector products, two gain products and the accumulate before
// m_tvalid rises.
// One request is in work at a time; s_tready is low until the result is taken.
// Reset (aresetn, synchronous) clears pose, last positions and gains.
module mecanum_odometry_integrator_core (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [127:0] s_tdata,   // a[31:0], b, c, d[127:96]
    input  wire          s_tuser,   // clear_pose
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [127:0] m_tdata,   // pose_x[47:0], pose_y[95:48], heading[127:96]
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [0:0]   cfg_index,
    input  wire  [31:0]  cfg_data
);
    moi_pkg::state_t state_reg, state_next;
    logic [31:0] lin_gain_reg, ang_gain_reg;
    logic [31:0] last_reg [4];
    logic primed_reg;
    logic signed [47:0] x_reg, y_reg;
    logic [31:0] hd_reg;
    logic signed [33:0] pa_reg, pb_reg; // deltas sums
    logic [31:0] dth_reg;
    // shared serial multiplier: acc += mcand when mplier bit set, shift
    logic [65:0] mc_reg;   // multiplicand
    logic [65:0] mp_reg;   // multiplier, shifted right
    logic [65:0] pr_reg;   // product accumulator
    logic [6:0]  cnt_reg;
    logic [1:0]  phase_reg; // which sub-product
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic flip_reg;
    logic signed [31:0] sn_reg, cs_reg;
    logic signed [65:0] vx_reg, vy_reg;
    logic signed [49:0] ix_reg, iy_reg;

    assign s_tready  = (state_reg == moi_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == moi_pkg::ST_OUT);
    assign m_tdata   = {hd_reg, y_reg, x_reg};

    logic signed [32:0] d [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d[i] = 33'(signed'(s_tdata[32*i +: 32] - last_reg[i]));
        end
    end

    // CORDIC step
    logic [4:0] ci;
    logic signed [33:0] xs, ys;
    logic [31:0] at;
    assign ci = cnt_reg[4:0];
    assign xs = cx_reg >>> ci;
    assign ys = cy_reg >>> ci;
    assign at = moi_pkg::atan_lut(ci);

    // vector products: sn*pa + cs*pb (x) ; sn*pb - cs*pa (y)
    logic signed [65:0] opa, opb;
    always_comb begin
        case (phase_reg)
            2'd0: begin opa = 66'(sn_reg); opb = 66'(pa_reg); end
            2'd1: begin opa = 66'(cs_reg); opb = 66'(pb_reg); end
            2'd2: begin opa = 66'(sn_reg); opb = 66'(pb_reg); end
            default: begin opa = 66'(cs_reg); opb = 66'(pa_reg); end
        endcase
    end

    logic [65:0] pr_add;
    assign pr_add = pr_reg + (mp_reg[0] ? mc_reg : 66'd0);

    // final rounding/saturation
    logic [65:0] magx, magy;
    logic signed [49:0] sx, sy;
    always_comb begin
        magx = vx_reg[65] ? 66'(-vx_reg) : 66'(vx_reg);
        magy = vy_reg[65] ? 66'(-vy_reg) : 66'(vy_reg);
        sx = 50'(x_reg) + ix_reg;
        sy = 50'(y_reg) + iy_reg;
    end

    logic signed [33:0] sum_now;
    assign sum_now = -34'(d[0]) + 34'(d[1]) - 34'(d[2]) + 34'(d[3]);
    // CORDIC angle, taken from the heading product on its last cycle
    logic [31:0] ang_in;
    logic [63:0] p64;
    logic [31:0] half;
    assign p64  = pr_add[63:0];
    assign half = 32'((p64 + 64'h10000) >> 17);
    assign ang_in = hd_reg + 32'h20000000 + half;

    function automatic logic signed [31:0] clampq(input logic signed [33:0] v);
        if (v > 34'sd1073741824) return 32'sd1073741824;
        if (v < -34'sd1073741824) return -32'sd1073741824;
        return 32'(v);
    endfunction

    // m = floor(|v|*g / 2^32), below 2^63; round half up at bit 14
    function automatic logic [49:0] rnd(input logic [65:0] m);
        return 50'((m + 66'd8192) >> 14);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] s);
        if (s > 50'(moi_pkg::POS_MAX)) return moi_pkg::POS_MAX;
        if (s < 50'(moi_pkg::POS_MIN)) return moi_pkg::POS_MIN;
        return 48'(s);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= moi_pkg::ST_IDLE;
            lin_gain_reg <= '0; ang_gain_reg <= '0;
            primed_reg <= 1'b0;
            x_reg <= '0; y_reg <= '0; hd_reg <= '0;
            for (int i = 0; i < 4; i++) last_reg[i] <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == moi_pkg::REG_LINEAR_GAIN) lin_gain_reg <= cfg_data;
                else ang_gain_reg <= cfg_data;
            end
            state_reg <= state_next;
            unique case (state_reg)
                moi_pkg::ST_IDLE: if (s_tvalid) begin
                    for (int i = 0; i < 4; i++) last_reg[i] <= s_tdata[32*i +: 32];
                    primed_reg <= 1'b1;
                    if (s_tuser) begin
                        x_reg <= '0; y_reg <= '0; hd_reg <= '0;
                    end
                    pa_reg <= 34'(d[0]) + 34'(d[3]);
                    pb_reg <= 34'(d[1]) + 34'(d[2]);
                    mc_reg <= 66'(ang_gain_reg);
                    mp_reg <= 66'({{32{sum_now[33]}}, sum_now});
                    pr_reg <= '0;
                    cnt_reg <= '0;
                end
                moi_pkg::ST_HMUL: begin
                    // product mod 2^64, multiplicand shifted left
                    pr_reg <= pr_add; mc_reg <= mc_reg << 1; mp_reg <= mp_reg >> 1;
                    if (cnt_reg == 7'd63) begin
                        dth_reg <= 32'((pr_add[63:0] + 64'h8000) >> 16);
                        // load CORDIC, folding [90, 270) deg by half a turn
                        flip_reg <= (ang_in[31:30] == 2'd1) || (ang_in[31:30] == 2'd2);
                        cz_reg <= 33'(signed'(((ang_in[31:30] == 2'd1) ||
                            (ang_in[31:30] == 2'd2)) ? ang_in - 32'h80000000 : ang_in));
                        cx_reg <= 34'(moi_pkg::CORDIC_X0);
                        cy_reg <= '0;
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                moi_pkg::ST_CORD: begin
                    if (cnt_reg < 7'(moi_pkg::NSTG)) begin
                        if (!cz_reg[32]) begin
                            cx_reg <= cx_reg - ys; cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - 33'(at);
                        end else begin
                            cx_reg <= cx_reg + ys; cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + 33'(at);
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                    end else begin
                        cs_reg <= clampq(flip_reg ? -cx_reg : cx_reg);
                        sn_reg <= clampq(flip_reg ? -cy_reg : cy_reg);
                        cnt_reg <= '0; phase_reg <= 2'd0; pr_reg <= '0;
                        vx_reg <= '0; vy_reg <= '0;
                    end
                end
                moi_pkg::ST_VMUL: begin
                    if (cnt_reg == 7'd0) begin
                        mc_reg <= opa; mp_reg <= opb; pr_reg <= '0;
                        cnt_reg <= 7'd1;
                    end else begin
                        pr_reg <= pr_add; mc_reg <= mc_reg << 1; mp_reg <= mp_reg >> 1;
                        if (cnt_reg == 7'd66) begin
                            cnt_reg <= '0;
                            phase_reg <= phase_reg + 2'd1;
                            case (phase_reg)
                                2'd0: vx_reg <= vx_reg + signed'(pr_add);
                                2'd1: vx_reg <= vx_reg + signed'(pr_add);
                                2'd2: vy_reg <= vy_reg + signed'(pr_add);
                                default: vy_reg <= vy_reg - signed'(pr_add);
                            endcase
                        end else begin
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                    end
                end
                moi_pkg::ST_GMUL: begin
                    // phase 0: |vx|*gain, phase 1: |vy|*gain; gain bits LSB first,
                    // accumulator shifts right once per gain bit, so the 32 gain bits leave the product >> 32
                    if (cnt_reg == 7'd0) begin
                        mc_reg <= (phase_reg == 2'd0) ? magx : magy;
                        mp_reg <= 66'(lin_gain_reg);
                        pr_reg <= '0; cnt_reg <= 7'd1;
                    end else begin
                        pr_reg <= pr_add >> 1; mp_reg <= mp_reg >> 1;
                        if (cnt_reg == 7'd32) begin
                            cnt_reg <= '0;
                            phase_reg <= phase_reg + 2'd1;
                            if (phase_reg == 2'd0)
                                ix_reg <= vx_reg[65] ? -50'(rnd(pr_add >> 1))
                                                     : 50'(rnd(pr_add >> 1));
                            else
                                iy_reg <= vy_reg[65] ? -50'(rnd(pr_add >> 1))
                                                     : 50'(rnd(pr_add >> 1));
                        end else begin
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                    end
                end
                moi_pkg::ST_ACC: begin
                    x_reg <= sat48(sx);
                    y_reg <= sat48(sy);
                    hd_reg <= hd_reg + dth_reg;
                end
                moi_pkg::ST_OUT: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            moi_pkg::ST_IDLE: if (s_tvalid)
                state_next = (s_tuser || !primed_reg) ? moi_pkg::ST_OUT : moi_pkg::ST_HMUL;
            moi_pkg::ST_HMUL: if (cnt_reg == 7'd63) state_next = moi_pkg::ST_CORD;
            moi_pkg::ST_CORD: if (cnt_reg == 7'(moi_pkg::NSTG))
                state_next = moi_pkg::ST_VMUL;
            moi_pkg::ST_VMUL: if (cnt_reg == 7'd66 && phase_reg == 2'd3)
                state_next = moi_pkg::ST_GMUL;
            moi_pkg::ST_GMUL: if (cnt_reg == 7'd32 && phase_reg == 2'd1)
                state_next = moi_pkg::ST_ACC;
            moi_pkg::ST_ACC: state_next = moi_pkg::ST_OUT;
            moi_pkg::ST_OUT: if (m_tready) state_next = moi_pkg::ST_IDLE;
            default: state_next = moi_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire
